### hw/rtl/ddsw_pkg.sv
// Shared types and constants for the dual-channel DAC waveform generator.
// Used by ddsw_core and the top level; no dependencies.
package ddsw_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ   = 2'd1;

  localparam logic [15:0] PERIOD_RST = 16'd200;
  localparam logic [15:0] FREQ_RST   = 16'd512;

  // Datapath widths
  localparam int unsigned MUL_W = 32;   // serial multiplier operand width
  localparam int unsigned DEN_W = 24;   // period * 256
  localparam int unsigned LVL_W = 10;

  // Q30 fixed-point constants
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [41:0] LVL_BASE    = 42'd1099511627776;  // 2^40
  localparam logic [LVL_W-1:0] LVL_MAX = 10'd1023;

  // DAC command word tags
  localparam logic [2:0] SINE_TAG = 3'b111;
  localparam logic [3:0] RAMP_TAG = 4'b1111;

  // Taylor series divisors, innermost term first
  localparam logic [2:0] SERIES_LAST = 3'd4;

  function automatic logic [6:0] series_div(logic [2:0] k);
    logic [6:0] d;
    case (k)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  typedef struct packed {
    logic [LVL_W-1:0] sine_lvl;
    logic [LVL_W-1:0] ramp_lvl;
  } ddsw_lvl_t;

endpackage

### hw/rtl/ddsw_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone.
module ddsw_mul #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]   a_q;
  logic [2*W-1:0] p_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [W:0]     sum;

  assign sum = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // product shifts right; the multiplier is consumed from the low end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {sum, p_q[W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

### hw/rtl/ddsw_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone. Divisor must be nonzero.
module ddsw_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NW);

  logic [NW-1:0] num_q;
  logic [DW-1:0] rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial, diff;
  logic          fits;

  assign trial = {rem_q, num_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      num_q <= {num_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/ddsw_core.sv
// Sample sequencer: phase, sine series and ramp on one serial multiplier and
// one serial divider. Depends on ddsw_pkg, ddsw_mul and ddsw_div.
module ddsw_core #(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        step_i,
  input  logic [15:0]        period_i,
  input  logic [15:0]        freq_i,
  output logic               done_o,
  output ddsw_pkg::ddsw_lvl_t lvl_o
);
  import ddsw_pkg::*;

  localparam int unsigned NW       = DEN_W + PHASE_BITS;
  localparam int unsigned TURN_SH  = 32 - PHASE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_MOD, S_PHASE, S_ANGLE, S_SQ,
    S_SDIV, S_SMUL, S_SIN, S_LVL1, S_LVL2, S_RAMP
  } state_e;

  state_e           state_q;
  logic             done_q, mul_go_q, div_go_q;
  logic [MUL_W-1:0] mul_a_q, mul_b_q;
  logic [NW-1:0]    div_num_q;
  logic [DEN_W-1:0] div_den_q;
  logic [15:0]      step_q, per_q;
  logic [1:0]       quad_q;
  logic [30:0]      a_q, s_q;
  logic [31:0]      a2_q;
  logic [40:0]      m_q;
  logic [2:0]       k_q;
  logic [LVL_W-1:0] sv_q, rv_q;

  logic               mul_done, div_done;
  logic [2*MUL_W-1:0] mul_prod;
  logic [NW-1:0]      div_quo;
  logic [DEN_W-1:0]   div_rem;

  ddsw_mul #(.W(MUL_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ddsw_div #(.NW(NW), .DW(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // phase to quarter-turn fraction, mirrored in odd quadrants
  logic [31:0] turn;
  logic [30:0] x_w;
  assign turn = 32'(div_quo[PHASE_BITS-1:0]) << TURN_SH;
  assign x_w  = turn[30] ? (ONE_Q30 - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};

  logic [30:0] t_w;
  assign t_w = ONE_Q30 - div_quo[30:0];

  logic [31:0] s_raw;
  logic [30:0] s_w;
  assign s_raw = mul_prod[61:30];
  assign s_w   = (s_raw > 32'(ONE_Q30)) ? ONE_Q30 : s_raw[30:0];

  logic [41:0] v_w;
  logic [10:0] v_top;
  logic [LVL_W-1:0] lvl_w;
  assign v_w   = quad_q[1] ? (LVL_BASE - 42'(m_q)) : (LVL_BASE + 42'(m_q));
  assign v_top = v_w[41:31];
  assign lvl_w = (v_top > 11'(LVL_MAX)) ? LVL_MAX : v_top[LVL_W-1:0];

  logic [25:0] ramp_num;
  logic [LVL_W-1:0] ramp_w;
  assign ramp_num = {step_q, 10'b0} - 26'(step_q);
  assign ramp_w   = (|div_quo[NW-1:LVL_W]) ? LVL_MAX : div_quo[LVL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            step_q   <= step_i;
            per_q    <= (period_i == 16'd0) ? 16'd1 : period_i;
            mul_a_q  <= MUL_W'(freq_i);
            mul_b_q  <= MUL_W'(step_i);
            mul_go_q <= 1'b1;
            state_q  <= S_PROD;
          end
        end
        S_PROD: begin
          if (mul_done) begin
            div_num_q <= NW'(mul_prod[31:0]);
            div_den_q <= {per_q, 8'b0};
            div_go_q  <= 1'b1;
            state_q   <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_done) begin
            div_num_q <= {div_rem, {PHASE_BITS{1'b0}}};
            div_go_q  <= 1'b1;
            state_q   <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (div_done) begin
            quad_q   <= turn[31:30];
            mul_a_q  <= MUL_W'(x_w);
            mul_b_q  <= HALF_PI_Q30;
            mul_go_q <= 1'b1;
            state_q  <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          if (mul_done) begin
            a_q      <= mul_prod[60:30];
            mul_a_q  <= MUL_W'(mul_prod[60:30]);
            mul_b_q  <= MUL_W'(mul_prod[60:30]);
            mul_go_q <= 1'b1;
            state_q  <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            a2_q      <= mul_prod[61:30];
            div_num_q <= NW'(mul_prod[61:30]);
            div_den_q <= DEN_W'(series_div(3'd0));
            k_q       <= 3'd0;
            div_go_q  <= 1'b1;
            state_q   <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            mul_b_q  <= MUL_W'(t_w);
            mul_go_q <= 1'b1;
            if (k_q == SERIES_LAST) begin
              mul_a_q <= MUL_W'(a_q);
              state_q <= S_SIN;
            end else begin
              mul_a_q <= a2_q;
              k_q     <= k_q + 3'd1;
              state_q <= S_SMUL;
            end
          end
        end
        S_SMUL: begin
          if (mul_done) begin
            div_num_q <= NW'(mul_prod[61:30]);
            div_den_q <= DEN_W'(series_div(k_q));
            div_go_q  <= 1'b1;
            state_q   <= S_SDIV;
          end
        end
        S_SIN: begin
          if (mul_done) begin
            s_q     <= s_w;
            state_q <= S_LVL1;
          end
        end
        S_LVL1: begin
          m_q     <= {s_q, 10'b0} - 41'(s_q);   // 1023 * s
          state_q <= S_LVL2;
        end
        S_LVL2: begin
          sv_q      <= lvl_w;
          div_num_q <= NW'(ramp_num);
          div_den_q <= DEN_W'(per_q);
          div_go_q  <= 1'b1;
          state_q   <= S_RAMP;
        end
        S_RAMP: begin
          if (div_done) begin
            rv_q    <= ramp_w;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o         = done_q;
  assign lvl_o.sine_lvl = sv_q;
  assign lvl_o.ramp_lvl = rv_q;

`ifndef ASSERT_OFF
  a_one_unit_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_go_q && div_go_q))
    else $error("multiplier and divider started together");

  a_mul_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_PROD || state_q == S_ANGLE || state_q == S_SQ ||
                  state_q == S_SMUL || state_q == S_SIN))
    else $error("multiplier finished in a state not waiting for it");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_MOD || state_q == S_PHASE || state_q == S_SDIV ||
                  state_q == S_RAMP))
    else $error("divider finished in a state not waiting for it");
`endif

endmodule

### hw/rtl/dual_channel_dac_waveform_generator.sv
// Top level of the dual-channel DAC waveform generator: handshakes,
// configuration registers, step counter, output register. Uses ddsw_pkg, ddsw_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, tick_i): a request with tick_i = 1
//   produces one pair of DAC words for the current step and advances the step
//   counter (wraps to zero once step+1 reaches period_steps); tick_i = 0 is
//   taken and dropped.
//   Output channel (out_valid_o/out_ready_i): sine_word_o = 0x7000 | sine << 2,
//   ramp_word_o = 0xF000 | ramp << 2.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0
//   period_steps, index 1 sine_freq_q8; other indexes ignored. Always ready.
//   Write only while no sample is in flight.
// Flow: one request at a time; each sample runs 8 serial multiplies and 8
//   serial divides in turn, and a new request is taken only once the previous
//   result has moved into the output register.
// Reset: period_steps = 200, sine_freq_q8 = 512, step counter zero, no output.
// Stall: a finished sample waits in the output register; the next request is
//   taken meanwhile, and its result waits inside the core until the output
//   register frees up.
module dual_channel_dac_waveform_generator #(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           tick_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [14:0]                    sine_word_o,
  output logic [15:0]                    ramp_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ddsw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import ddsw_pkg::*;

  logic [15:0] period_q, freq_q, step_q;
  logic        busy_q, pend_q, out_valid_q;
  logic [14:0] sine_q;
  logic [15:0] ramp_q;

  logic        start, move, core_done;
  logic [16:0] step_inc;
  ddsw_lvl_t   lvl;

  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = 1'b1;
  assign start       = in_valid_i && in_ready_o && tick_i;
  assign move        = pend_q && (!out_valid_q || out_ready_i);
  assign step_inc    = {1'b0, step_q} + 17'd1;

  ddsw_core #(.PHASE_BITS(PHASE_BITS)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .step_i   (step_q),
    .period_i (period_q),
    .freq_i   (freq_q),
    .done_o   (core_done),
    .lvl_o    (lvl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RST;
      freq_q      <= FREQ_RST;
      step_q      <= '0;
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PERIOD: period_q <= cfg_data_i;
          CFG_FREQ:   freq_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (start) begin
        busy_q <= 1'b1;
        step_q <= (step_inc >= {1'b0, period_q}) ? 16'd0 : step_inc[15:0];
      end
      if (core_done) begin
        pend_q <= 1'b1;
      end
      if (move) begin
        pend_q      <= 1'b0;
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      sine_q <= {SINE_TAG, lvl.sine_lvl, 2'b00};
      ramp_q <= {RAMP_TAG, lvl.ramp_lvl, 2'b00};
    end
  end

  assign out_valid_o = out_valid_q;
  assign sine_word_o = sine_q;
  assign ramp_word_o = ramp_q;

`ifndef ASSERT_OFF
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> (busy_q && !pend_q))
    else $error("core finished with no request in flight");

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("new request taken while a result is pending");

  a_load_from_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("output became valid without a pending result");
`endif

endmodule

### tb/dual_channel_dac_waveform_generator_tb.sv
// Testbench for the dual-channel DAC waveform generator: directed and random tick
// traffic with random config changes, checked against a built-in sample predictor.
// Depends on ddsw_pkg and dual_channel_dac_waveform_generator.
module dual_channel_dac_waveform_generator_tb;

  localparam int unsigned PHASE_BITS    = 16;
  localparam int          SAMPLE_CYCLES = 612;        // idle wait in settle() after the results drain
  localparam int          RANDOM_TICKS  = 1150;
  localparam longint      RUN_LIMIT     = 64'd300_000_000;

  localparam logic [ddsw_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [ddsw_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam bit [63:0] UNITY_Q30   = 64'd1 << 30;
  localparam bit [63:0] RIGHT_ANGLE = 64'd1686629713;  // pi/2 in Q30

  typedef struct packed {
    bit [14:0] sine;
    bit [15:0] ramp;
  } dac_pair_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic                              tick_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [14:0]                       sine_word_o;
  logic [15:0]                       ramp_word_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [ddsw_pkg::CFG_IDX_W-1:0]    cfg_index_i;
  logic [15:0]                       cfg_data_i;

  dual_channel_dac_waveform_generator #(
    .PHASE_BITS(PHASE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .tick_i     (tick_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sine_word_o(sine_word_o),
    .ramp_word_o(ramp_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state
  bit [15:0] period_q;
  bit [15:0] freq_q;
  bit [15:0] step_q;
  dac_pair_t expected_samples[$];

  bit        calm;
  int        mismatches;
  int        samples_checked;
  int        reg_writes;
  int        idle_requests;
  dac_pair_t want;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 900);
  endfunction

  function automatic bit [63:0] quarter_sine(bit [63:0] a);
    bit [63:0] a2, t, s;
    a2 = (a * a) >> 30;
    t  = UNITY_Q30 - a2 / 110;
    t  = UNITY_Q30 - ((a2 * t) >> 30) / 72;
    t  = UNITY_Q30 - ((a2 * t) >> 30) / 42;
    t  = UNITY_Q30 - ((a2 * t) >> 30) / 20;
    t  = UNITY_Q30 - ((a2 * t) >> 30) / 6;
    s  = (a * t) >> 30;
    return (s > UNITY_Q30) ? UNITY_Q30 : s;
  endfunction

  function automatic bit [9:0] sine_level(bit [15:0] step, bit [15:0] per, bit [15:0] frq);
    bit [63:0] den, rem, phase, p, f, x, a, s, v;
    bit [1:0]  quad;
    den   = 64'(per) * 256;
    rem   = (64'(frq) * 64'(step)) % den;
    phase = (rem << PHASE_BITS) / den;
    p     = (phase << (32 - PHASE_BITS)) & 64'hFFFF_FFFF;
    quad  = p[31:30];
    f     = p & (UNITY_Q30 - 1);
    x     = quad[0] ? (UNITY_Q30 - f) : f;
    a     = (x * RIGHT_ANGLE) >> 30;
    s     = quarter_sine(a);
    // second half of the turn subtracts from mid-scale
    v     = quad[1] ? ((64'd1 << 40) - 64'd1023 * s) : ((64'd1 << 40) + 64'd1023 * s);
    v     = v >> 31;
    return (v > 1023) ? 10'd1023 : v[9:0];
  endfunction

  // Works out the DAC pair for the current step and advances the step counter.
  task automatic take_tick();
    bit [15:0] per;
    bit [16:0] nxt;
    bit [63:0] rv;
    dac_pair_t pair;
    per = (period_q == 16'd0) ? 16'd1 : period_q;
    rv  = (64'd1023 * 64'(step_q)) / 64'(per);
    if (rv > 1023) rv = 1023;
    pair.sine = 15'h7000 | (15'(sine_level(step_q, per, freq_q)) << 2);
    pair.ramp = 16'hF000 | (16'(rv[9:0]) << 2);
    expected_samples.push_back(pair);
    nxt    = 17'(step_q) + 17'd1;
    step_q = (nxt >= 17'(period_q)) ? 16'd0 : nxt[15:0];
  endtask

  // Valid stays up after acceptance; the next call lowers it only when a gap follows.
  task automatic send_request(bit t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= t;
    do @(posedge clk_i); while (!in_ready_o);
    if (t) take_tick();
    else idle_requests++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_for_results();
    repeat (SAMPLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ddsw_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ddsw_pkg::CFG_PERIOD: period_q = val;
      ddsw_pkg::CFG_FREQ:   freq_q   = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic test_defaults();
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(ddsw_pkg::CFG_PERIOD, 16'd1);
    write_reg(ddsw_pkg::CFG_FREQ, 16'd0);
    send_request(1'b1);
    send_request(1'b1);
    settle();
    // zero period divides as one and always wraps
    write_reg(ddsw_pkg::CFG_PERIOD, 16'd0);
    write_reg(ddsw_pkg::CFG_FREQ, 16'hFFFF);
    send_request(1'b1);
    send_request(1'b1);
    settle();
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    write_reg(CFG_SPARE_LO, 16'h0000);
    write_reg(ddsw_pkg::CFG_PERIOD, 16'hFFFF);
    send_request(1'b1);
    send_request(1'b1);
  endtask

  // One waveform period per loop over four steps hits each quadrant boundary.
  task automatic test_quadrants();
    settle();
    write_reg(ddsw_pkg::CFG_PERIOD, 16'd4);
    write_reg(ddsw_pkg::CFG_FREQ, 16'd256);
    repeat (5) send_request(1'b1);
  endtask

  task automatic test_period_lowered();
    settle();
    write_reg(ddsw_pkg::CFG_PERIOD, 16'd20);
    write_reg(ddsw_pkg::CFG_FREQ, 16'h0180);
    repeat (8) send_request(1'b1);
    settle();
    // step now past the period: ramp saturates, counter wraps
    write_reg(ddsw_pkg::CFG_PERIOD, 16'd3);
    send_request(1'b1);
    send_request(1'b1);
  endtask

  task automatic test_random_traffic(int target);
    int        done, burst, r;
    bit        t;
    logic [15:0] per, frq;
    done = 0;
    while (done < target) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 60)      per = 16'($urandom_range(1, 64));
      else if (r < 80) per = 16'($urandom_range(65, 1000));
      else if (r < 84) per = 16'd0;
      else if (r < 88) per = 16'd1;
      else if (r < 92) per = 16'hFFFF;
      else             per = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 40)      frq = 16'($urandom_range(0, 65535));
      else if (r < 80) frq = 16'($urandom_range(0, 1024));
      else if (r < 88) frq = 16'd0;
      else             frq = 16'hFFFF;
      r = $urandom_range(0, 99);
      if (r < 85) write_reg(ddsw_pkg::CFG_PERIOD, per);
      if (r >= 15 || r < 5) write_reg(ddsw_pkg::CFG_FREQ, frq);
      if ($urandom_range(0, 6) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                  16'($urandom_range(0, 65535)));
      calm  = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(20, 90);
      repeat (burst) begin
        t = ($urandom_range(0, 6) != 0);
        send_request(t);
        done++;
        if ($urandom_range(0, 99) == 0) wait_for_results();
      end
      calm = 1'b0;
    end
  endtask

  // Result sink with random back-pressure.
  initial begin
    int hold;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample sine %h ramp %h", $time, sine_word_o, ramp_word_o);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (sine_word_o !== want.sine) begin
          $display("%0t: sine_word expected %h got %h", $time, want.sine, sine_word_o);
          mismatches++;
        end
        if (ramp_word_o !== want.ramp) begin
          $display("%0t: ramp_word expected %h got %h", $time, want.ramp, ramp_word_o);
          mismatches++;
        end
        samples_checked++;
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    tick_i      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= ddsw_pkg::CFG_PERIOD;
    cfg_data_i  <= 16'd0;
    period_q    = ddsw_pkg::PERIOD_RST;
    freq_q      = ddsw_pkg::FREQ_RST;
    step_q      = 16'd0;
    calm        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_register_extremes();
    test_quadrants();
    test_period_lowered();
    test_random_traffic(RANDOM_TICKS);
    settle();

    $display("Checked %0d sample pairs across %0d register writes and %0d idle requests,",
             samples_checked, reg_writes, idle_requests);
    $display("including period extremes, counter wrap and steps past a lowered period.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
